// File: rtl/core/triangle_slope_angle_macros.svh
// assertion macros used by the checker
`ifndef TRIANGLE_SLOPE_ANGLE_MACROS_SVH
`define TRIANGLE_SLOPE_ANGLE_MACROS_SVH

// same-cycle implication
`define TSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsa check failed");

// next-cycle implication
`define TSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsa check failed");

`endif

// File: rtl/core/tsa_pkg.sv
package tsa_pkg;

    localparam int COORD_BITS_DEF      = 32;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ANGLE_W             = 18;
    localparam int MANT_W              = 30;
    localparam int CORDIC_ITER         = 30;
    localparam int XW                  = 34;
    localparam int ZW                  = 33;
    localparam logic [31:0] PI30       = 32'd3373259426;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = {ANGLE_W{1'b1}};

    typedef struct packed {
        logic ny_neg;
        logic degen;
    } t_side;

    // atan(2^-i) in units of 2^-30, truncated
    function automatic logic [31:0] atan30(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000007;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/tsa_normal.sv
module tsa_normal #(
    parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_a_z,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_b_z,
    input  logic signed [COORD_BITS-1:0]  i_c_x,
    input  logic signed [COORD_BITS-1:0]  i_c_y,
    input  logic signed [COORD_BITS-1:0]  i_c_z,
    output logic                          o_valid,
    output logic [2*COORD_BITS+2:0]       o_mag_x,
    output logic [2*COORD_BITS+2:0]       o_mag_y,
    output logic [2*COORD_BITS+2:0]       o_mag_z,
    output tsa_pkg::t_side                o_side
);
    import tsa_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;

    logic [3:0] r_valid;
    logic signed [EW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PW-1:0] r_p_yz, r_p_zy, r_p_zx, r_p_xz, r_p_xy, r_p_yx;
    logic signed [NW-1:0] r_nx, r_ny, r_nz;
    logic [NW-1:0] r_mag_x, r_mag_y, r_mag_z;
    t_side r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edges from the first corner
            r_ux <= EW'(i_b_x) - EW'(i_a_x);
            r_uy <= EW'(i_b_y) - EW'(i_a_y);
            r_uz <= EW'(i_b_z) - EW'(i_a_z);
            r_vx <= EW'(i_c_x) - EW'(i_a_x);
            r_vy <= EW'(i_c_y) - EW'(i_a_y);
            r_vz <= EW'(i_c_z) - EW'(i_a_z);
            r_p_yz <= r_uy * r_vz;
            r_p_zy <= r_uz * r_vy;
            r_p_zx <= r_uz * r_vx;
            r_p_xz <= r_ux * r_vz;
            r_p_xy <= r_ux * r_vy;
            r_p_yx <= r_uy * r_vx;
            r_nx <= NW'(r_p_yz) - NW'(r_p_zy);
            r_ny <= NW'(r_p_zx) - NW'(r_p_xz);
            r_nz <= NW'(r_p_xy) - NW'(r_p_yx);
            r_mag_x <= r_nx[NW-1] ? (~r_nx + 1'b1) : r_nx;
            r_mag_y <= r_ny[NW-1] ? (~r_ny + 1'b1) : r_ny;
            r_mag_z <= r_nz[NW-1] ? (~r_nz + 1'b1) : r_nz;
            r_side.ny_neg <= r_ny[NW-1];
            r_side.degen  <= (r_nx == '0) && (r_ny == '0) && (r_nz == '0);
        end
    end

    assign o_valid = r_valid[3];
    assign o_mag_x = r_mag_x;
    assign o_mag_y = r_mag_y;
    assign o_mag_z = r_mag_z;
    assign o_side  = r_side;

endmodule

// File: rtl/core/tsa_norm.sv
module tsa_norm #(
    parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [2*COORD_BITS+2:0]        i_mag_x,
    input  logic [2*COORD_BITS+2:0]        i_mag_y,
    input  logic [2*COORD_BITS+2:0]        i_mag_z,
    input  tsa_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [tsa_pkg::MANT_W-1:0]     o_my,
    output logic [2*tsa_pkg::MANT_W:0]     o_sum,
    output tsa_pkg::t_side                 o_side
);
    import tsa_pkg::*;

    localparam int NW = 2 * COORD_BITS + 3;
    localparam int LW = $clog2(NW + 1);
    localparam int QW = 2 * MANT_W;

    logic [3:0] r_valid;
    t_side r_side [4];
    logic [NW-1:0] r_mag_x, r_mag_y, r_mag_z;
    logic [LW-1:0] r_len;
    logic [MANT_W-1:0] r_mx, r_my, r_mz, r_my7, r_my8;
    logic [QW-1:0] r_sqx, r_sqz;
    logic [QW:0] r_sum;
    logic [NW-1:0] any;
    logic [LW-1:0] len;
    logic [NW+MANT_W-1:0] shx, shy, shz;

    // bit length of the largest magnitude
    always_comb begin
        any = i_mag_x | i_mag_y | i_mag_z;
        len = '0;
        for (int i = 0; i < NW; i++) begin
            if (any[i]) begin
                len = LW'(i + 1);
            end
        end
    end

    assign shx = {r_mag_x, {MANT_W{1'b0}}} >> r_len;
    assign shy = {r_mag_y, {MANT_W{1'b0}}} >> r_len;
    assign shz = {r_mag_z, {MANT_W{1'b0}}} >> r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_mag_x <= i_mag_x;
            r_mag_y <= i_mag_y;
            r_mag_z <= i_mag_z;
            r_len   <= len;
            r_mx <= shx[MANT_W-1:0];
            r_my <= shy[MANT_W-1:0];
            r_mz <= shz[MANT_W-1:0];
            r_sqx <= r_mx * r_mx;
            r_sqz <= r_mz * r_mz;
            r_my7 <= r_my;
            r_sum <= (QW+1)'(r_sqx) + (QW+1)'(r_sqz);
            r_my8 <= r_my7;
        end
    end

    assign o_valid = r_valid[3];
    assign o_my    = r_my8;
    assign o_sum   = r_sum;
    assign o_side  = r_side[3];

endmodule

// File: rtl/core/tsa_isqrt.sv
module tsa_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2*tsa_pkg::MANT_W:0]  i_sum,
    input  logic [tsa_pkg::MANT_W-1:0]  i_my,
    input  tsa_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [tsa_pkg::MANT_W:0]    o_root,
    output logic [tsa_pkg::MANT_W-1:0]  o_my,
    output tsa_pkg::t_side              o_side
);
    import tsa_pkg::*;

    localparam int SW   = 2 * MANT_W + 4;
    localparam int ITER = SW / 2;
    localparam int NST  = ITER / 2;

    function automatic logic [2*SW-1:0] sq_step(input logic [SW-1:0] v,
                                                input logic [SW-1:0] r,
                                                input int k);
        logic [SW-1:0] b;
        logic [SW-1:0] t;
        logic [SW-1:0] vo;
        logic [SW-1:0] ro;
        b = SW'(1) << (SW - 2 - 2 * k);
        t = r + b;
        if (v >= t) begin
            vo = v - t;
            ro = (r >> 1) + b;
        end else begin
            vo = v;
            ro = r >> 1;
        end
        return {vo, ro};
    endfunction

    logic [SW-1:0] w_v [NST+1];
    logic [SW-1:0] w_r [NST+1];
    logic          w_valid [NST+1];
    logic [MANT_W-1:0] w_my [NST+1];
    t_side         w_side [NST+1];

    assign w_v[0]     = SW'(i_sum);
    assign w_r[0]     = '0;
    assign w_valid[0] = i_valid;
    assign w_my[0]    = i_my;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [2*SW-1:0] s0, s1;
        logic [SW-1:0] r_v, r_r;
        logic r_valid;
        logic [MANT_W-1:0] r_my;
        t_side r_side;

        assign s0 = sq_step(w_v[g], w_r[g], 2 * g);
        assign s1 = sq_step(s0[2*SW-1:SW], s0[SW-1:0], 2 * g + 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v    <= s1[2*SW-1:SW];
                r_r    <= s1[SW-1:0];
                r_my   <= w_my[g];
                r_side <= w_side[g];
            end
        end

        assign w_v[g+1]     = r_v;
        assign w_r[g+1]     = r_r;
        assign w_valid[g+1] = r_valid;
        assign w_my[g+1]    = r_my;
        assign w_side[g+1]  = r_side;
    end

    assign o_valid = w_valid[NST];
    assign o_root  = w_r[NST][MANT_W:0];
    assign o_my    = w_my[NST];
    assign o_side  = w_side[NST];

endmodule

// File: rtl/core/tsa_cordic.sv
module tsa_cordic #(
    parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [tsa_pkg::MANT_W:0]     i_root,
    input  logic [tsa_pkg::MANT_W-1:0]   i_my,
    input  tsa_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [tsa_pkg::ANGLE_W-1:0]  o_angle,
    output logic                         o_degen
);
    import tsa_pkg::*;

    localparam int NST = CORDIC_ITER / 2;
    localparam int SH  = MANT_W - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] PI_Z = ZW'(PI30);

    logic signed [XW-1:0] w_x [NST+1];
    logic signed [XW-1:0] w_y [NST+1];
    logic signed [ZW-1:0] w_z [NST+1];
    logic                 w_valid [NST+1];
    t_side                w_side [NST+1];

    assign w_x[0]     = XW'(i_my);
    assign w_y[0]     = XW'(i_root);
    assign w_z[0]     = '0;
    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < NST; g++) begin : g_st
        localparam int K0 = 2 * g;
        localparam int K1 = 2 * g + 1;
        localparam logic signed [ZW-1:0] T0 = ZW'(atan30(5'(K0)));
        localparam logic signed [ZW-1:0] T1 = ZW'(atan30(5'(K1)));
        logic signed [XW-1:0] x1, y1, x2, y2;
        logic signed [ZW-1:0] z1, z2;
        logic signed [XW-1:0] r_x, r_y;
        logic signed [ZW-1:0] r_z;
        logic r_valid;
        t_side r_side;

        always_comb begin
            if (!w_y[g][XW-1]) begin
                x1 = w_x[g] + (w_y[g] >>> K0);
                y1 = w_y[g] - (w_x[g] >>> K0);
                z1 = w_z[g] + T0;
            end else begin
                x1 = w_x[g] - (w_y[g] >>> K0);
                y1 = w_y[g] + (w_x[g] >>> K0);
                z1 = w_z[g] - T0;
            end
            if (!y1[XW-1]) begin
                x2 = x1 + (y1 >>> K1);
                y2 = y1 - (x1 >>> K1);
                z2 = z1 + T1;
            end else begin
                x2 = x1 - (y1 >>> K1);
                y2 = y1 + (x1 >>> K1);
                z2 = z1 - T1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= x2;
                r_y    <= y2;
                r_z    <= z2;
                r_side <= w_side[g];
            end
        end

        assign w_x[g+1]     = r_x;
        assign w_y[g+1]     = r_y;
        assign w_z[g+1]     = r_z;
        assign w_valid[g+1] = r_valid;
        assign w_side[g+1]  = r_side;
    end

    logic [31:0] zc, zf;
    logic [32:0] rsum, rsh;
    logic [ANGLE_W-1:0] n_angle;
    logic [ANGLE_W-1:0] r_angle;
    logic r_degen, r_valid;

    // clamp, fold for downward normal, round and saturate; zero for a degenerate triangle
    always_comb begin
        if (w_z[NST][ZW-1]) begin
            zc = '0;
        end else if (w_z[NST] > PI_Z) begin
            zc = PI30;
        end else begin
            zc = w_z[NST][31:0];
        end
        zf   = w_side[NST].ny_neg ? (PI30 - zc) : zc;
        rsum = {1'b0, zf} + (33'(1) << (SH - 1));
        rsh  = rsum >> SH;
        if (w_side[NST].degen) begin
            n_angle = '0;
        end else if (rsh > 33'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = rsh[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= w_valid[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
            r_degen <= w_side[NST].degen;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;
    assign o_degen = r_degen;

endmodule

// File: rtl/core/triangle_slope_angle.sv
// throughput: one transaction per cycle; the whole pipeline advances as one
// and freezes only while a finished result is held by i_stall
// reset: synchronous, active low; clears all valid bits, payload not reset
module triangle_slope_angle #(
    parameter int COORD_BITS      = tsa_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_a_z,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_b_z,
    input  logic signed [COORD_BITS-1:0]  i_c_x,
    input  logic signed [COORD_BITS-1:0]  i_c_y,
    input  logic signed [COORD_BITS-1:0]  i_c_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tsa_pkg::ANGLE_W-1:0]   o_slope_angle,
    output logic                          o_degenerate
);
    import tsa_pkg::*;

    localparam int NW = 2 * COORD_BITS + 3;

    logic en;
    logic v1, v2, v3;
    logic [NW-1:0] mag_x, mag_y, mag_z;
    t_side side1, side2, side3;
    logic [MANT_W-1:0] my2, my3;
    logic [2*MANT_W:0] sum2;
    logic [MANT_W:0] root3;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    tsa_normal #(.COORD_BITS(COORD_BITS)) u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_c_z   (i_c_z),
        .o_valid (v1),
        .o_mag_x (mag_x),
        .o_mag_y (mag_y),
        .o_mag_z (mag_z),
        .o_side  (side1)
    );

    tsa_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_mag_x (mag_x),
        .i_mag_y (mag_y),
        .i_mag_z (mag_z),
        .i_side  (side1),
        .o_valid (v2),
        .o_my    (my2),
        .o_sum   (sum2),
        .o_side  (side2)
    );

    tsa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_sum   (sum2),
        .i_my    (my2),
        .i_side  (side2),
        .o_valid (v3),
        .o_root  (root3),
        .o_my    (my3),
        .o_side  (side3)
    );

    tsa_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v3),
        .i_root  (root3),
        .i_my    (my3),
        .i_side  (side3),
        .o_valid (o_valid),
        .o_angle (o_slope_angle),
        .o_degen (o_degenerate)
    );

endmodule

// File: rtl/core/tsa_checker.sv
`include "triangle_slope_angle_macros.svh"

module tsa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [tsa_pkg::ANGLE_W-1:0]  o_slope_angle,
    input logic                         o_degenerate
);
    import tsa_pkg::*;

    // a degenerate triangle reports a zero angle
    `TSA_ASSERT_IMP(a_degen_zero, o_valid && o_degenerate, o_slope_angle == '0)

    // input side stalls only while a result is held at the output
    `TSA_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)

    // a held result stays put
    `TSA_ASSERT_NXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_slope_angle) && $stable(o_degenerate))

endmodule

bind triangle_slope_angle tsa_checker u_tsa_checker (.*);
